// ===== rtl/stg_pkg.sv =====
// ---------------------------------------------------------------------------
// Sine tone generator package
// Shared constants, configuration register indices, pipeline control type
// and the constant functions that build the quarter-wave sine table.
// ---------------------------------------------------------------------------
`default_nettype none

package stg_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam int unsigned SAMPLE_BITS_DEF = 16;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned PHASE_W    = 32;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned OUT_W      = 16;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN  = 2'd2;

    // Register values after reset: 1 kHz at 48 kHz, no offset, unity gain.
    localparam logic [PHASE_W-1:0] PHASE_STEP_RST   = 32'd89478485;
    localparam logic [PHASE_W-1:0] PHASE_OFFSET_RST = 32'd0;
    localparam logic [GAIN_W-1:0]  LINEAR_GAIN_RST  = 16'd4096;

    // Output saturation limits and the magnitude that maps to the negative limit.
    localparam logic [OUT_W-1:0] SAMPLE_POS_MAX = 16'h7FFF;
    localparam logic [OUT_W:0]   MAG_LIMIT      = 17'h08000;

    // pi/2 in Q30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Divisors (2n)(2n+1) of the Taylor terms of sin.
    localparam logic [63:0] TAYLOR_DIV [12] = '{
        64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic s3_load;
        logic s4_load;
    } t_pipe_ctl;

    // sin(x) in Q30 for an angle x in Q30, by a thirteen term Taylor series.
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 0; n < 12; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if ((n % 2) == 0) begin
                sum = (sum >= term) ? (sum - term) : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // One table entry: sin(x) scaled to the amplitude, rounded and clamped.
    function automatic logic [63:0] tab_entry(input logic [63:0] x, input logic [63:0] amp);
        logic [63:0] v;
        v = (sine_q30(x) * amp + (64'd1 << 29)) >> 30;
        if (v > amp) begin
            v = amp;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stg_regs.sv =====
// ---------------------------------------------------------------------------
// Sine tone generator configuration registers
// Holds phase step, phase offset and linear gain, written by index.
// ---------------------------------------------------------------------------
`default_nettype none

module stg_regs import stg_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [PHASE_W-1:0]         o_phase_step,
    output logic [PHASE_W-1:0]         o_phase_offset,
    output logic [GAIN_W-1:0]          o_linear_gain
);

    logic [PHASE_W-1:0] r_phase_step,   n_phase_step;
    logic [PHASE_W-1:0] r_phase_offset, n_phase_offset;
    logic [GAIN_W-1:0]  r_linear_gain,  n_linear_gain;

    always_comb begin
        n_phase_step   = r_phase_step;
        n_phase_offset = r_phase_offset;
        n_linear_gain  = r_linear_gain;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PHASE_STEP: begin
                    n_phase_step = i_cfg_data[PHASE_W-1:0];
                end
                CFG_PHASE_OFFSET: begin
                    n_phase_offset = i_cfg_data[PHASE_W-1:0];
                end
                CFG_LINEAR_GAIN: begin
                    n_linear_gain = i_cfg_data[GAIN_W-1:0];
                end
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= PHASE_STEP_RST;
            r_phase_offset <= PHASE_OFFSET_RST;
            r_linear_gain  <= LINEAR_GAIN_RST;
        end else begin
            r_phase_step   <= n_phase_step;
            r_phase_offset <= n_phase_offset;
            r_linear_gain  <= n_linear_gain;
        end
    end

    assign o_phase_step   = r_phase_step;
    assign o_phase_offset = r_phase_offset;
    assign o_linear_gain  = r_linear_gain;

endmodule

`default_nettype wire

// ===== rtl/stg_phase.sv =====
// ---------------------------------------------------------------------------
// Sine tone generator phase stage
// Phase accumulator, lookup angle and quarter-wave table address.
// ---------------------------------------------------------------------------
`default_nettype none

module stg_phase import stg_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_pipe_ctl                      i_ctl,
    input  wire logic                           i_restart,
    input  wire logic                           i_block_end,
    input  wire logic [PHASE_W-1:0]             i_phase_step,
    input  wire logic [PHASE_W-1:0]             i_phase_offset,
    output logic [$clog2(TABLE_DEPTH)-1:0]      o_rom_addr,
    output logic                                o_neg,
    output logic                                o_last
);

    localparam int unsigned ABITS  = $clog2(TABLE_DEPTH);
    localparam int unsigned RESI_W = PHASE_W - 2;
    localparam int unsigned PROD_W = RESI_W + ABITS;

    logic [PHASE_W-1:0] r_acc, n_acc;
    logic [PHASE_W-1:0] r_phase1;
    logic               r_last1;
    logic               r_neg2;
    logic               r_last2;

    logic [PHASE_W-1:0] w_angle;
    logic [PROD_W-1:0]  w_idx_prod;
    logic [ABITS-1:0]   w_idx;

    // Restart clears the accumulator before this word's increment.
    assign n_acc = (i_restart ? '0 : r_acc) + i_phase_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.s1_load) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_load) begin
            r_phase1 <= n_acc;
            r_last1  <= i_block_end;
        end
        if (i_ctl.s2_load) begin
            r_neg2  <= w_angle[PHASE_W-1];
            r_last2 <= r_last1;
        end
    end

    assign w_angle    = r_phase1 + i_phase_offset;
    assign w_idx_prod = PROD_W'(w_angle[RESI_W-1:0]) * PROD_W'(TABLE_DEPTH);
    assign w_idx      = w_idx_prod[RESI_W +: ABITS];

    // Odd quadrants read the table mirrored.
    assign o_rom_addr = w_angle[PHASE_W-2] ? (ABITS'(TABLE_DEPTH - 1) - w_idx) : w_idx;
    assign o_neg      = r_neg2;
    assign o_last     = r_last2;

endmodule

`default_nettype wire

// ===== rtl/stg_rom.sv =====
// ---------------------------------------------------------------------------
// Sine tone generator quarter-wave table
// Constant sine table built at elaboration, read through a registered port.
// ---------------------------------------------------------------------------
`default_nettype none

module stg_rom import stg_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] i_addr,
    output logic [SAMPLE_BITS-2:0]             o_data
);

    localparam int unsigned ABITS  = $clog2(TABLE_DEPTH);
    localparam int unsigned WIDTH  = SAMPLE_BITS - 1;
    localparam logic [63:0] AMP    = (64'd1 << WIDTH) - 64'd1;

    logic [WIDTH-1:0] w_tab [TABLE_DEPTH];
    logic [WIDTH-1:0] r_data;

    // Entry k holds the sine at the centre of its slot of the quarter wave.
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_tab
        localparam logic [63:0] XK =
            (HALF_PI_Q30 * 64'(2 * k + 1)) / (64'd2 * 64'(TABLE_DEPTH));
        assign w_tab[k] = WIDTH'(tab_entry(XK, AMP));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_tab[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== rtl/stg_scale.sv =====
// ---------------------------------------------------------------------------
// Sine tone generator gain stage
// Multiplies the table value by the Q4.12 gain, rounds, applies the sign
// and saturates to a Q1.15 sample.
// ---------------------------------------------------------------------------
`default_nettype none

module stg_scale import stg_pkg::*; #(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire t_pipe_ctl              i_ctl,
    input  wire logic [SAMPLE_BITS-2:0] i_tab,
    input  wire logic                   i_neg,
    input  wire logic                   i_last,
    input  wire logic [GAIN_W-1:0]      i_linear_gain,
    output logic [OUT_W-1:0]            o_sample,
    output logic                        o_last
);

    localparam int unsigned TAB_W  = SAMPLE_BITS - 1;
    localparam int unsigned PROD_W = TAB_W + GAIN_W;
    localparam int unsigned SHIFT  = SAMPLE_BITS - 4;
    localparam int unsigned MAG_W  = PROD_W + 1 - SHIFT;
    localparam logic [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) << (SHIFT - 1);

    logic [PROD_W-1:0] r_prod;
    logic              r_neg3;
    logic              r_last3;
    logic [OUT_W-1:0]  r_sample;
    logic              r_last4;

    logic [PROD_W:0]   w_rnd;
    logic [MAG_W-1:0]  w_mag;
    logic [OUT_W:0]    w_mag_c;
    logic [OUT_W:0]    w_mag_n;
    logic [OUT_W-1:0]  n_sample;

    always_ff @(posedge i_clk) begin
        if (i_ctl.s3_load) begin
            r_prod  <= PROD_W'(i_tab) * PROD_W'(i_linear_gain);
            r_neg3  <= i_neg;
            r_last3 <= i_last;
        end
        if (i_ctl.s4_load) begin
            r_sample <= n_sample;
            r_last4  <= r_last3;
        end
    end

    // Round half up on the magnitude, so the result is symmetric in sign.
    assign w_rnd   = {1'b0, r_prod} + RND_HALF;
    assign w_mag   = w_rnd[SHIFT +: MAG_W];
    assign w_mag_c = (w_mag > MAG_W'(MAG_LIMIT)) ? MAG_LIMIT : w_mag[OUT_W:0];
    assign w_mag_n = ~w_mag_c + (OUT_W + 1)'(1);

    always_comb begin
        if (r_neg3) begin
            n_sample = w_mag_n[OUT_W-1:0];
        end else if (w_mag_c >= MAG_LIMIT) begin
            n_sample = SAMPLE_POS_MAX;
        end else begin
            n_sample = w_mag_c[OUT_W-1:0];
        end
    end

    assign o_sample = r_sample;
    assign o_last   = r_last4;

endmodule

`default_nettype wire

// ===== rtl/sine_tone_generator_top.sv =====
// A word passes the phase, table, product and sample registers. Throughput: one
// word per cycle unless stalled, set by the four-stage pipeline with one
// table read and one multiply per word; a stalled output fills bubbles first.
// Reset (synchronous, active low) clears the phase accumulator and the stage
// valid flags and restores the register defaults; the table needs no clearing.
// ---------------------------------------------------------------------------
// Sine tone generator
// Direct digital synthesis oscillator: phase accumulator, quarter-wave sine
// table and linear gain, one sample per tick word.
// ---------------------------------------------------------------------------
`default_nettype none

module sine_tone_generator_top import stg_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write channel.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // Tick stream in.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [0] restart, [7:1] zero
    input  wire logic                  s_axis_tlast,   // block_end
    // Sample stream out.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_W-1:0]           m_axis_tdata,   // [15:0] sample
    output logic                       m_axis_tlast    // last
);

    localparam int unsigned ABITS = $clog2(TABLE_DEPTH);

    logic [PHASE_W-1:0]     w_phase_step;
    logic [PHASE_W-1:0]     w_phase_offset;
    logic [GAIN_W-1:0]      w_linear_gain;
    logic [ABITS-1:0]       w_rom_addr;
    logic [SAMPLE_BITS-2:0] w_tab;
    logic                   w_neg;
    logic                   w_last2;

    logic      r_v1, r_v2, r_v3, r_v4;
    logic      w_free1, w_free2, w_free3, w_free4;
    t_pipe_ctl w_ctl;

    // A stage may load when it is empty or its word moves on in this cycle.
    assign w_free4 = !r_v4 || m_axis_tready;
    assign w_free3 = !r_v3 || w_free4;
    assign w_free2 = !r_v2 || w_free3;
    assign w_free1 = !r_v1 || w_free2;

    assign w_ctl.s1_load = s_axis_tvalid && w_free1;
    assign w_ctl.s2_load = r_v1 && w_free2;
    assign w_ctl.s3_load = r_v2 && w_free3;
    assign w_ctl.s4_load = r_v3 && w_free4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= w_ctl.s1_load || (r_v1 && !w_ctl.s2_load);
            r_v2 <= w_ctl.s2_load || (r_v2 && !w_ctl.s3_load);
            r_v3 <= w_ctl.s3_load || (r_v3 && !w_ctl.s4_load);
            r_v4 <= w_ctl.s4_load || (r_v4 && !m_axis_tready);
        end
    end

    stg_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_phase_step   (w_phase_step),
        .o_phase_offset (w_phase_offset),
        .o_linear_gain  (w_linear_gain)
    );

    stg_phase #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_phase (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_restart      (s_axis_tdata[0]),
        .i_block_end    (s_axis_tlast),
        .i_phase_step   (w_phase_step),
        .i_phase_offset (w_phase_offset),
        .o_rom_addr     (w_rom_addr),
        .o_neg          (w_neg),
        .o_last         (w_last2)
    );

    stg_rom #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_ctl.s2_load),
        .i_addr (w_rom_addr),
        .o_data (w_tab)
    );

    stg_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk         (i_clk),
        .i_ctl         (w_ctl),
        .i_tab         (w_tab),
        .i_neg         (w_neg),
        .i_last        (w_last2),
        .i_linear_gain (w_linear_gain),
        .o_sample      (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_free1;
    assign m_axis_tvalid = r_v4;

endmodule

`default_nettype wire

// ===== rtl/stg_checker.sv =====
// ---------------------------------------------------------------------------
// Sine tone generator checker
// Port-level assertions on the stream handshakes and pipeline timing.
// ---------------------------------------------------------------------------
`default_nettype none

module stg_checker import stg_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             s_axis_tlast,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata,
    input wire logic             m_axis_tlast
);

    // A sample waiting on the output keeps its word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // With no sample waiting the pipeline always has room for a new tick.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready with empty output");

    // With the output free flowing, an accepted tick reaches the output with its flag.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready
            ##1 m_axis_tready ##1 m_axis_tready |=>
            m_axis_tvalid && (m_axis_tlast == $past(s_axis_tlast, 4)))
        else $error("sample did not arrive after four cycles");

endmodule

bind sine_tone_generator_top stg_checker u_stg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
